// ===== design/pcx_pkg.sv =====
// Package for the PCX run-length decoder: queue command type, byte codes,
// register indexes and reset values. It depends on nothing else.
`default_nettype none
package pcx_pkg;

    localparam logic [7:0] RUN_MARK   = 8'hC0;
    localparam logic [7:0] COUNT_MASK = 8'h3F;

    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] REG_LINE_LENGTH = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ROW_COUNT   = 2'd1;

    localparam logic [15:0] LINE_LENGTH_RESET = 16'd320;
    localparam logic [15:0] ROW_COUNT_RESET   = 16'd200;

    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);

    // One pixel value and how many times it is to be repeated.
    typedef struct packed {
        logic [7:0] value;
        logic [5:0] count;
    } t_cmd;

endpackage
`default_nettype wire

// ===== design/pcx_front.sv =====
// Front end of the PCX decoder: accepts compressed bytes, recognises run
// headers and hands repeat commands to the queue. Uses pcx_pkg.
`default_nettype none
module pcx_front (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic [7:0]  i_data_byte,
    input  wire logic        i_queue_full,
    output logic             o_push,
    output pcx_pkg::t_cmd    o_cmd
);
    import pcx_pkg::*;

    logic       r_awaiting;
    logic       n_awaiting;
    logic [5:0] r_count;
    logic [5:0] n_count;
    logic       accept;
    logic       is_header;

    assign o_ready   = !i_queue_full;
    assign accept    = i_valid && o_ready;
    assign is_header = (i_data_byte & RUN_MARK) == RUN_MARK;

    always_comb begin
        n_awaiting = r_awaiting;
        n_count    = r_count;
        o_push     = 1'b0;
        o_cmd.value = i_data_byte;
        o_cmd.count = 6'd1;
        if (accept) begin
            if (r_awaiting) begin
                // The byte after a header is the run value, whatever it is.
                n_awaiting  = 1'b0;
                n_count     = 6'd0;
                o_push      = 1'b1;
                o_cmd.count = r_count;
            end else if (is_header) begin
                n_awaiting = 1'b1;
                n_count    = 6'(i_data_byte & COUNT_MASK);
            end else begin
                o_push = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_awaiting <= 1'b0;
            r_count    <= 6'd0;
        end else begin
            r_awaiting <= n_awaiting;
            r_count    <= n_count;
        end
    end

endmodule
`default_nettype wire

// ===== design/pcx_queue.sv =====
// Short command queue between the front and back of the PCX decoder.
// Uses pcx_pkg for the command type and the depth.
`default_nettype none
module pcx_queue (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_push,
    input  wire pcx_pkg::t_cmd i_cmd,
    input  wire logic        i_pop,
    output logic             o_full,
    output logic             o_empty,
    output pcx_pkg::t_cmd    o_head
);
    import pcx_pkg::*;

    t_cmd                   r_mem [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0] r_wr_ptr;
    logic [QUEUE_PTR_W-1:0] r_rd_ptr;
    logic [QUEUE_PTR_W:0]   r_fill;
    logic                   do_push;
    logic                   do_pop;

    assign o_full  = r_fill == (QUEUE_PTR_W+1)'(QUEUE_DEPTH);
    assign o_empty = r_fill == '0;
    assign o_head  = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_fill   <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= r_wr_ptr + QUEUE_PTR_W'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + QUEUE_PTR_W'(1);
            end
            case ({do_push, do_pop})
                2'b10:   r_fill <= r_fill + (QUEUE_PTR_W+1)'(1);
                2'b01:   r_fill <= r_fill - (QUEUE_PTR_W+1)'(1);
                default: r_fill <= r_fill;
            endcase
        end
    end

endmodule
`default_nettype wire

// ===== design/pcx_back.sv =====
// Back end of the PCX decoder: expands queued commands into pixels, tracks
// column and row against the configuration registers. Uses pcx_pkg.
`default_nettype none
module pcx_back (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_cfg_valid,
    input  wire logic [pcx_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  wire logic [15:0]                     i_cfg_data,
    input  wire logic                            i_queue_empty,
    input  wire pcx_pkg::t_cmd                   i_head,
    output logic                                 o_pop,
    output logic                                 o_valid,
    input  wire logic                            i_ready,
    output logic [7:0]                           o_pixel_value,
    output logic [15:0]                          o_column,
    output logic [15:0]                          o_row,
    output logic                                 o_end_of_line,
    output logic                                 o_end_of_image,
    output logic                                 o_last
);
    import pcx_pkg::*;

    logic [15:0] r_line_length;
    logic [15:0] r_row_count;
    logic [15:0] r_col;
    logic [15:0] r_row;
    logic [5:0]  r_sent;
    logic        r_image_done;
    logic        r_out_valid;
    logic [7:0]  r_out_pixel;
    logic [15:0] r_out_col;
    logic [15:0] r_out_row;
    logic        r_out_eol;
    logic        r_out_eoi;
    logic        r_out_last;

    logic [15:0] last_col;
    logic [15:0] last_row;
    logic        eol;
    logic        eoi;
    logic        slot_free;
    logic        head_valid;
    logic        skip;
    logic        emit;
    logic        fin;

    // A register value of zero wraps to the all-ones last position.
    assign last_col   = r_line_length - 16'd1;
    assign last_row   = r_row_count - 16'd1;
    assign eol        = r_col >= last_col;
    assign eoi        = eol && (r_row >= last_row);
    assign slot_free  = !r_out_valid || i_ready;
    assign head_valid = !i_queue_empty;
    // Zero-length runs and everything after the image are dropped.
    assign skip       = head_valid && ((i_head.count == 6'd0) || r_image_done);
    assign emit       = head_valid && !skip && slot_free;
    assign fin        = ((7'(r_sent) + 7'd1) == 7'(i_head.count)) || eoi;
    assign o_pop      = skip || (emit && fin);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line_length <= LINE_LENGTH_RESET;
            r_row_count   <= ROW_COUNT_RESET;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_LINE_LENGTH: r_line_length <= i_cfg_data;
                REG_ROW_COUNT:   r_row_count   <= i_cfg_data;
                default:         ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col        <= 16'd0;
            r_row        <= 16'd0;
            r_sent       <= 6'd0;
            r_image_done <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (o_pop) begin
                r_sent <= 6'd0;
            end else if (emit) begin
                r_sent <= r_sent + 6'd1;
            end
            if (emit) begin
                if (eoi) begin
                    r_image_done <= 1'b1;
                    r_col        <= 16'd0;
                    r_row        <= 16'd0;
                end else if (eol) begin
                    r_col <= 16'd0;
                    r_row <= r_row + 16'd1;
                end else begin
                    r_col <= r_col + 16'd1;
                end
            end
            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_out_pixel <= i_head.value;
            r_out_col   <= r_col;
            r_out_row   <= r_row;
            r_out_eol   <= eol;
            r_out_eoi   <= eoi;
            r_out_last  <= fin;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_pixel_value  = r_out_pixel;
    assign o_column       = r_out_col;
    assign o_row          = r_out_row;
    assign o_end_of_line  = r_out_eol;
    assign o_end_of_image = r_out_eoi;
    assign o_last         = r_out_last;

`ifndef NO_ASSERTIONS
    a_sent_below_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        emit |-> (7'(r_sent) < 7'(i_head.count)))
        else $error("pixel count of a run overran its command");
    a_done_after_eoi: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (emit && eoi) |=> (r_image_done && o_end_of_image && o_last))
        else $error("end of image did not close the image and the command");
    a_silent_when_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_image_done |-> !emit)
        else $error("pixel produced after the image was complete");
    a_eoi_has_eol: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_end_of_image) |-> o_end_of_line)
        else $error("end of image without end of line");
`endif

endmodule
`default_nettype wire

// ===== design/pcx_rle_decoder.sv =====
// Path: a literal byte passes the command queue, then the output register.
// Throughput: one input byte per cycle while the queue has room, one pixel
// per cycle at the output while the receiver is ready; a run holds the back
// end until its pixels are sent, and the two-entry queue then stalls input.
// Reset: synchronous, active low; clears control state and loads 320 and 200
// into the line length and row count registers. No clearing pass is needed.
`default_nettype none
module pcx_rle_decoder (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_valid,
    output logic                                 o_ready,
    input  wire logic [7:0]                      i_data_byte,
    output logic                                 o_valid,
    input  wire logic                            i_ready,
    output logic [7:0]                           o_pixel_value,
    output logic [15:0]                          o_column,
    output logic [15:0]                          o_row,
    output logic                                 o_end_of_line,
    output logic                                 o_end_of_image,
    output logic                                 o_last,
    input  wire logic                            i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  wire logic [pcx_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  wire logic [15:0]                     i_cfg_data
);
    import pcx_pkg::*;

    logic push;
    logic pop;
    logic queue_full;
    logic queue_empty;
    t_cmd push_cmd;
    t_cmd head_cmd;

    assign o_cfg_ready = 1'b1;

    pcx_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_data_byte  (i_data_byte),
        .i_queue_full (queue_full),
        .o_push       (push),
        .o_cmd        (push_cmd)
    );

    pcx_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (push_cmd),
        .i_pop   (pop),
        .o_full  (queue_full),
        .o_empty (queue_empty),
        .o_head  (head_cmd)
    );

    pcx_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_valid    (i_cfg_valid),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_queue_empty  (queue_empty),
        .i_head         (head_cmd),
        .o_pop          (pop),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_pixel_value  (o_pixel_value),
        .o_column       (o_column),
        .o_row          (o_row),
        .o_end_of_line  (o_end_of_line),
        .o_end_of_image (o_end_of_image),
        .o_last         (o_last)
    );

endmodule
`default_nettype wire

// ===== test/tb_pcx_rle_decoder.sv =====
// Testbench for pcx_rle_decoder: drives compressed bytes and register writes, predicts
// every decoded pixel with its position and marks, and checks each output transfer.
// Depends on design/pcx_pkg.sv and design/pcx_rle_decoder.sv with the modules it uses.
module tb_pcx_rle_decoder;
    import pcx_pkg::*;

    localparam int HALF_PERIOD    = 10;
    localparam int RESET_CYCLES   = 5;
    localparam int SETTLE_CYCLES  = 6;
    localparam int END_CYCLES     = 16;
    localparam int HOLDOFF_CYCLES = 400;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int MAX_REPORTS    = 10;
    localparam int PHASE_BYTES    = 45;

    typedef struct packed {
        logic [7:0]  pix;
        logic [15:0] col;
        logic [15:0] row;
        logic        eol;
        logic        eoi;
        logic        last_one;
    } t_pixel;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n;
    logic                 i_valid;
    logic                 o_ready;
    logic [7:0]           i_data_byte;
    logic                 o_valid;
    logic                 i_ready = 1'b0;
    logic [7:0]           o_pixel_value;
    logic [15:0]          o_column;
    logic [15:0]          o_row;
    logic                 o_end_of_line;
    logic                 o_end_of_image;
    logic                 o_last;
    logic                 i_cfg_valid;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [15:0]          i_cfg_data;

    pcx_rle_decoder dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_data_byte    (i_data_byte),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_pixel_value  (o_pixel_value),
        .o_column       (o_column),
        .o_row          (o_row),
        .o_end_of_line  (o_end_of_line),
        .o_end_of_image (o_end_of_image),
        .o_last         (o_last),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    always begin
        #(HALF_PERIOD) i_clk = 1'b1;
        #(HALF_PERIOD) i_clk = 1'b0;
    end

    // Decoder state as predicted from the accepted bytes.
    logic [15:0] line_len_reg;
    logic [15:0] row_cnt_reg;
    logic        run_pending;
    logic [5:0]  run_len;
    logic [15:0] col_pos;
    logic [15:0] row_pos;
    logic        img_done;

    t_pixel      expected_pixels[$];
    t_pixel      want_pixel;

    int unsigned bytes_sent   = 0;
    int unsigned pixels_seen  = 0;
    int unsigned cfg_writes   = 0;
    int unsigned error_count  = 0;
    int unsigned burst_left   = 0;
    int unsigned quiet_cycles = 0;
    int unsigned holdoff_left = 0;
    bit          holdoff_req  = 1'b0;
    logic [7:0]  rx_cycle     = '0;

    function automatic t_pixel next_pixel(input logic [7:0] v);
        t_pixel      p;
        logic [15:0] last_col;
        logic [15:0] last_row;
        // A register value of zero wraps to a last index of 0xFFFF, i.e. 65536 entries.
        last_col   = line_len_reg - 16'd1;
        last_row   = row_cnt_reg - 16'd1;
        p.pix      = v;
        p.col      = col_pos;
        p.row      = row_pos;
        p.eol      = (col_pos >= last_col);
        p.eoi      = p.eol && (row_pos >= last_row);
        p.last_one = 1'b0;
        if (p.eoi) begin
            img_done = 1'b1;
            col_pos  = '0;
            row_pos  = '0;
        end else if (p.eol) begin
            col_pos = '0;
            row_pos = row_pos + 16'd1;
        end else begin
            col_pos = col_pos + 16'd1;
        end
        return p;
    endfunction

    function automatic void decode_byte(input logic [7:0] b);
        t_pixel      p;
        int unsigned n;
        if (img_done)
            return;
        if (run_pending) begin
            run_pending = 1'b0;
            n           = run_len;
            run_len     = '0;
            while (n != 0 && !img_done) begin
                p          = next_pixel(b);
                n          = n - 1;
                p.last_one = (n == 0) || img_done;
                expected_pixels.push_back(p);
            end
        end else if ((b & RUN_MARK) == RUN_MARK) begin
            run_pending = 1'b1;
            run_len     = 6'(b & COUNT_MASK);
        end else begin
            p          = next_pixel(b);
            p.last_one = 1'b1;
            expected_pixels.push_back(p);
        end
    endfunction

    // The sender works in bursts; valid is lowered when a burst ends or the sender
    // is paused, and stays low for a random wait before a new burst starts.
    task automatic send_byte(input logic [7:0] b);
        if (burst_left == 0) begin
            repeat ($urandom_range(1, 8)) @(posedge i_clk);
            burst_left = $urandom_range(1, 24);
        end
        i_valid     <= 1'b1;
        i_data_byte <= b;
        do @(posedge i_clk); while (!o_ready);
        bytes_sent = bytes_sent + 1;
        decode_byte(b);
        burst_left = burst_left - 1;
        if (burst_left == 0)
            i_valid <= 1'b0;
    endtask

    task automatic pause_sender();
        if (burst_left != 0) begin
            i_valid    <= 1'b0;
            burst_left = 0;
        end
    endtask

    task automatic wait_drained();
        pause_sender();
        while (expected_pixels.size() != 0) @(posedge i_clk);
        // A run header leaves nothing to wait for, so give the block time to take it in.
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] val);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        if (idx == REG_LINE_LENGTH)
            line_len_reg = val;
        else if (idx == REG_ROW_COUNT)
            row_cnt_reg = val;
        cfg_writes = cfg_writes + 1;
    endtask

    task automatic send_random_group();
        int unsigned pick;
        logic [5:0]  cnt;
        pick = $urandom_range(0, 99);
        if (pick < 45) begin
            send_byte(8'($urandom_range(0, 191)));
        end else if (pick < 90) begin
            // Mostly short runs so that line ends and run splits come often.
            if ($urandom_range(0, 9) < 7)
                cnt = 6'($urandom_range(0, 8));
            else
                cnt = 6'($urandom_range(0, 63));
            send_byte(RUN_MARK | {2'b00, cnt});
            send_byte(8'($urandom));
        end else begin
            send_byte(8'($urandom));
        end
    endtask

    task automatic test_literals();
        send_byte(8'h00);
        send_byte(8'h3F);
        send_byte(8'h40);
        send_byte(8'h7F);
        send_byte(8'h80);
        send_byte(8'hBF);
    endtask

    task automatic test_runs();
        send_byte(8'hC3);
        send_byte(8'hFF);
        // Longest run, with a value that itself looks like a run header.
        send_byte(8'hFF);
        send_byte(8'hC0);
        // An empty run still swallows its value byte.
        send_byte(8'hC0);
        send_byte(8'h55);
        send_byte(8'hC2);
        send_byte(8'hC5);
    endtask

    task automatic test_zero_registers();
        wait_drained();
        write_reg(REG_LINE_LENGTH, 16'd0);
        write_reg(REG_ROW_COUNT, 16'd0);
        send_byte(8'hC5);
        send_byte(8'h11);
        send_byte(8'h22);
    endtask

    task automatic test_single_column();
        wait_drained();
        // The column is already past the new last column, so the line ends at once.
        write_reg(REG_LINE_LENGTH, 16'd1);
        write_reg(REG_ROW_COUNT, 16'hFFFF);
        send_byte(8'hC4);
        send_byte(8'h99);
        send_byte(8'h01);
    endtask

    task automatic test_random_settings();
        logic [15:0] len;
        logic [15:0] rows;
        int unsigned lo;
        int unsigned start;
        for (int ph = 0; ph < 6; ph++) begin
            wait_drained();
            case (ph)
                0:       len = 16'($urandom_range(1, 16));
                1:       len = 16'hFFFF;
                2:       len = 16'($urandom_range(1, 64));
                3:       len = LINE_LENGTH_RESET;
                4:       len = 16'($urandom_range(1, 65535));
                default: len = 16'($urandom_range(2, 8));
            endcase
            // The row count stays well ahead of the current row so the image goes on.
            case (ph % 3)
                0:       rows = 16'd0;
                1:       rows = 16'hFFFF;
                default: begin
                    lo = row_pos + 4000;
                    if (lo > 65535)
                        lo = 65535;
                    rows = 16'($urandom_range(lo, 65535));
                end
            endcase
            write_reg(REG_LINE_LENGTH, len);
            write_reg(REG_ROW_COUNT, rows);
            start = bytes_sent;
            while (bytes_sent - start < PHASE_BYTES)
                send_random_group();
        end
    endtask

    task automatic test_output_holdoff();
        holdoff_req = 1'b1;
        for (int i = 0; i < 20; i++) begin
            send_byte(RUN_MARK | 8'($urandom_range(10, 20)));
            send_byte(8'($urandom));
        end
    endtask

    task automatic test_sender_drain();
        for (int i = 0; i < 3; i++) begin
            repeat (6) send_random_group();
            wait_drained();
        end
    endtask

    task automatic test_image_end();
        wait_drained();
        if (run_pending) begin
            send_byte(8'h00);
            wait_drained();
        end
        // Every row is now at or past the last one, so the image ends with this line
        // and the full-length run is cut short.
        write_reg(REG_LINE_LENGTH, 16'd8);
        write_reg(REG_ROW_COUNT, 16'd1);
        send_byte(8'hFF);
        send_byte(8'hAA);
        send_byte(8'hC3);
        send_byte(8'h10);
        for (int i = 0; i < 10; i++)
            send_byte(8'($urandom));
    endtask

    // Receiver: cycles through steady, random and periodic stall patterns, and holds
    // off completely for a long stretch when asked.
    always @(posedge i_clk) begin
        rx_cycle <= rx_cycle + 8'd1;
        if (holdoff_req) begin
            holdoff_req  = 1'b0;
            holdoff_left = HOLDOFF_CYCLES;
        end
        if (holdoff_left != 0) begin
            holdoff_left = holdoff_left - 1;
            i_ready <= 1'b0;
        end else begin
            case (rx_cycle[7:6])
                2'd0:    i_ready <= 1'b1;
                2'd1:    i_ready <= ($urandom_range(0, 3) != 0);
                2'd2:    i_ready <= ($urandom_range(0, 2) == 0);
                default: i_ready <= (rx_cycle[2:1] != 2'd0);
            endcase
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            pixels_seen = pixels_seen + 1;
            if (expected_pixels.size() == 0) begin
                if (error_count < MAX_REPORTS)
                    $display("unexpected pixel %h at column %0d row %0d",
                             o_pixel_value, o_column, o_row);
                error_count = error_count + 1;
            end else begin
                want_pixel = expected_pixels.pop_front();
                if (o_pixel_value !== want_pixel.pix || o_column !== want_pixel.col ||
                    o_row !== want_pixel.row || o_end_of_line !== want_pixel.eol ||
                    o_end_of_image !== want_pixel.eoi || o_last !== want_pixel.last_one) begin
                    if (error_count < MAX_REPORTS) begin
                        $display("pixel %0d expected: value %h col %0d row %0d eol %b eoi %b last %b",
                                 pixels_seen, want_pixel.pix, want_pixel.col, want_pixel.row,
                                 want_pixel.eol, want_pixel.eoi, want_pixel.last_one);
                        $display("pixel %0d actual:   value %h col %0d row %0d eol %b eoi %b last %b",
                                 pixels_seen, o_pixel_value, o_column, o_row,
                                 o_end_of_line, o_end_of_image, o_last);
                    end
                    error_count = error_count + 1;
                end
            end
        end
    end

    // Any transfer on any channel counts as progress.
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && o_ready) || (o_valid && i_ready) ||
            (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles == WATCHDOG_LIMIT) begin
                $display("timed out after %0d idle cycles with %0d pixels outstanding",
                         WATCHDOG_LIMIT, expected_pixels.size());
                $display("status: fail");
                $finish;
            end
        end
    end

    initial begin
        i_rst_n      = 1'b0;
        i_valid      = 1'b0;
        i_data_byte  = '0;
        i_cfg_valid  = 1'b0;
        i_cfg_index  = REG_LINE_LENGTH;
        i_cfg_data   = '0;
        line_len_reg = LINE_LENGTH_RESET;
        row_cnt_reg  = ROW_COUNT_RESET;
        run_pending  = 1'b0;
        run_len      = '0;
        col_pos      = '0;
        row_pos      = '0;
        img_done     = 1'b0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_literals();
        test_runs();
        test_zero_registers();
        test_single_column();
        test_random_settings();
        test_output_holdoff();
        test_sender_drain();
        test_image_end();

        wait_drained();
        repeat (END_CYCLES) @(posedge i_clk);
        $display("Sent %0d bytes, checked %0d pixels, made %0d register writes.",
                 bytes_sent, pixels_seen, cfg_writes);
        $display("Covered wrapped registers, one-column lines, output hold-off and image end.");
        if (error_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end
endmodule
